// ----- sv/cau_pkg.sv -----
// Shared constants, operation codes and beat types for the complex arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

  // Operand and result word width (signed fixed point)
  localparam int WORD_BITS     = 32;
  // Default number of fraction bits
  localparam int FRAC_BITS_DEF = 16;
  // Width of the operation code field
  localparam int OP_BITS       = 3;

  typedef enum logic [OP_BITS-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_NEG = 3'd4,
    OP_CMP = 3'd5
  } op_t;

  typedef struct packed {
    logic [OP_BITS-1:0]          req_type;
    logic signed [WORD_BITS-1:0] a_re;
    logic signed [WORD_BITS-1:0] a_im;
    logic signed [WORD_BITS-1:0] b_re;
    logic signed [WORD_BITS-1:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] res_re;
    logic signed [WORD_BITS-1:0] res_im;
    logic                        is_equal;
    logic                        div_zero;
    logic                        overflow;
  } cau_out_t;

endpackage

`default_nettype wire

// ----- sv/cau_mul.sv -----
// Two-stage signed multiplier built from half-width partial products.
`timescale 1ns / 1ps
`default_nettype none

module cau_mul (
  input  logic                                  clk,
  input  logic signed [cau_pkg::WORD_BITS-1:0]  a,
  input  logic signed [cau_pkg::WORD_BITS-1:0]  b,
  output logic signed [2*cau_pkg::WORD_BITS-1:0] p
);

  localparam int W   = cau_pkg::WORD_BITS;
  localparam int PW  = 2 * W;
  localparam int LW  = W / 2;          // low slice, taken unsigned
  localparam int HW  = W - LW;         // high slice, keeps the sign
  localparam int HHW = 2 * HW;         // high x high
  localparam int CRW = HW + LW + 1;    // cross terms
  localparam int LLW = 2 * LW + 2;     // low x low

  logic signed [LW:0]   a_lo, b_lo;
  logic signed [HW-1:0] a_hi, b_hi;

  logic signed [HHW-1:0]    pp_hh_r;
  logic signed [CRW-1:0]    pp_hl_r;
  logic signed [CRW-1:0]    pp_lh_r;
  logic signed [LLW-1:0]    pp_ll_r;
  logic signed [PW-1:0]     p_r;

  assign a_lo = $signed({1'b0, a[LW-1:0]});
  assign b_lo = $signed({1'b0, b[LW-1:0]});
  assign a_hi = a[W-1:LW];
  assign b_hi = b[W-1:LW];

  // stage 1: partial products
  always_ff @(posedge clk) begin
    pp_hh_r <= HHW'(a_hi) * HHW'(b_hi);
    pp_hl_r <= CRW'(a_hi) * CRW'(b_lo);
    pp_lh_r <= CRW'(a_lo) * CRW'(b_hi);
    pp_ll_r <= LLW'(a_lo) * LLW'(b_lo);
  end

  // stage 2: weighted sum
  always_ff @(posedge clk) begin
    p_r <= (PW'(pp_hh_r) <<< (2 * LW)) + (PW'(pp_hl_r) <<< LW) +
           (PW'(pp_lh_r) <<< LW) + PW'(pp_ll_r);
  end

  assign p = p_r;

endmodule

`default_nettype wire

// ----- sv/cau_div.sv -----
// Pipelined restoring divider, two numerator lanes over one shared divisor.
`timescale 1ns / 1ps
`default_nettype none

module cau_div #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  logic [1:0][2*cau_pkg::WORD_BITS-1:0]      mag,
  input  logic [2*cau_pkg::WORD_BITS-1:0]           den,
  output logic [1:0][cau_pkg::WORD_BITS-1:0]        quo,
  output logic [1:0]                                q_ovf
);

  localparam int W  = cau_pkg::WORD_BITS;
  localparam int PW = 2 * W;
  localparam int NW = PW + FRAC_BITS;   // numerator scaled by 2^FRAC_BITS
  localparam int RW = W + FRAC_BITS;    // part above the W quotient bits

  logic [1:0][NW-1:0] n_full;
  logic [1:0][RW-1:0] r_init;
  logic [1:0]         ovf_init;

  // Quotient is known to fit W bits once the top part is below the divisor
  logic [PW-1:0] den_r [0:W-1];
  logic [PW-1:0] rem_r [0:1][0:W-1];
  logic [W-1:0]  lo_r  [0:1][0:W-1];
  logic [W-1:0]  q_r   [0:1][0:W];
  logic          ov_r  [0:1][0:W];

  logic [PW:0]   trial   [0:1][1:W];
  logic [PW:0]   diff    [0:1][1:W];
  logic          ge      [0:1][1:W];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      n_full[l]   = NW'(mag[l]) << FRAC_BITS;
      r_init[l]   = n_full[l][NW-1:W];
      ovf_init[l] = PW'(r_init[l]) >= den;
      for (int k = 1; k <= W; k++) begin
        trial[l][k] = {rem_r[l][k-1], lo_r[l][k-1][W-k]};
        diff[l][k]  = trial[l][k] - {1'b0, den_r[k-1]};
        ge[l][k]    = trial[l][k] >= {1'b0, den_r[k-1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    den_r[0] <= den;
    for (int k = 1; k < W; k++) begin
      den_r[k] <= den_r[k-1];
    end
    for (int l = 0; l < 2; l++) begin
      rem_r[l][0] <= ovf_init[l] ? '0 : PW'(r_init[l]);
      lo_r[l][0]  <= n_full[l][W-1:0];
      q_r[l][0]   <= '0;
      ov_r[l][0]  <= ovf_init[l];
      for (int k = 1; k < W; k++) begin
        rem_r[l][k] <= ge[l][k] ? PW'(diff[l][k]) : PW'(trial[l][k]);
        lo_r[l][k]  <= lo_r[l][k-1];
      end
      for (int k = 1; k <= W; k++) begin
        q_r[l][k]  <= q_r[l][k-1] | (W'(ge[l][k]) << (W - k));
        ov_r[l][k] <= ov_r[l][k-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      quo[l]   = q_r[l][W];
      q_ovf[l] = ov_r[l][W];
    end
  end

endmodule

`default_nettype wire

// ----- sv/complex_arith_unit_top.sv -----
// Top level of the complex arithmetic unit: add, sub, mul, div, negate, compare.
//
//  channel | ports                     | beat
//  --------+---------------------------+---------------------------------------
//  input   | start, busy, in_item      | taken at a clock edge with start high
//          |                           | and busy low
//  result  | out_valid, out_item       | one-cycle strobe, no back-pressure
//
// Flow: one beat may enter on every clock. Every operation takes the same
// path (input register, the product and sign stages, the divider, the output
// register), so results leave in order, each with out_valid high for one cycle.
// The divider does one restoring step per quotient bit, one register stage each.
// Reset: rst_n is synchronous, active low, and clears every valid bit; data
// registers are not reset. Stalls: busy is always low and nothing stalls.
`timescale 1ns / 1ps
`default_nettype none

module complex_arith_unit_top #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cau_pkg::cau_in_t  in_item,
  output logic              out_valid,
  output cau_pkg::cau_out_t out_item
);

  localparam int W   = cau_pkg::WORD_BITS;
  localparam int PW  = 2 * W;        // full product
  localparam int SW  = 2 * W + 1;    // sum of two products
  localparam int XW  = W + 1;        // sum of two words
  localparam int DL  = W;            // last index of the divider-aligned delay line

  localparam logic signed [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MAX_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0]        HALF_U  = {1'b1, {(W-1){1'b0}}};

  // result of everything except divide, formed before the divider
  typedef struct packed {
    logic signed [W-1:0] re;
    logic signed [W-1:0] im;
    logic                eq;
    logic                ovf;
  } dres_t;

  // what rides alongside the divider
  typedef struct packed {
    logic [cau_pkg::OP_BITS-1:0] op;
    logic [1:0]                  neg;
    logic                        dz;
    dres_t                       d;
  } sb_t;

  // ---- saturation helpers ------------------------------------------------
  // each returns {overflow, value}

  function automatic logic [W:0] sat_x(input logic signed [XW-1:0] x);
    if (x[XW-1] != x[XW-2]) begin
      sat_x = {1'b1, x[XW-1] ? MAX_NEG : MAX_POS};
    end else begin
      sat_x = {1'b0, x[W-1:0]};
    end
  endfunction

  // floor shift by FRAC_BITS, then clamp to the word
  function automatic logic [W:0] sat_wide(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] y;
    logic                 all_one;
    logic                 all_zero;
    y        = x >>> FRAC_BITS;
    all_one  = &y[SW-1:W-1];
    all_zero = ~|y[SW-1:W-1];
    if (all_one || all_zero) begin
      sat_wide = {1'b0, y[W-1:0]};
    end else begin
      sat_wide = {1'b1, y[SW-1] ? MAX_NEG : MAX_POS};
    end
  endfunction

  // quotient magnitude plus sign to a word; negative side reaches -2^(W-1)
  function automatic logic [W:0] div_sat(input logic [W-1:0] q, input logic qo,
                                         input logic neg);
    if (neg) begin
      if (qo || (q > HALF_U)) begin
        div_sat = {1'b1, MAX_NEG};
      end else begin
        div_sat = {1'b0, ~q + W'(1)};
      end
    end else begin
      if (qo || q[W-1]) begin
        div_sat = {1'b1, MAX_POS};
      end else begin
        div_sat = {1'b0, q};
      end
    end
  endfunction

  // ---- input beat ----------------------------------------------------------
  logic             in_acc;
  logic             v1_r;
  cau_pkg::cau_in_t s1_r;

  assign busy   = 1'b0;
  assign in_acc = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= in_item;
    end
  end

  // ---- stage 2: cheap operations, multiplier partials ---------------------
  logic              v2_r;
  logic [cau_pkg::OP_BITS-1:0] op2_r;
  dres_t             d2_r, d2_nxt;
  logic [W:0]        sat_re, sat_im;

  always_comb begin
    d2_nxt = '0;
    sat_re = '0;
    sat_im = '0;
    case (s1_r.req_type)
      cau_pkg::OP_ADD: begin
        sat_re = sat_x(XW'(s1_r.a_re) + XW'(s1_r.b_re));
        sat_im = sat_x(XW'(s1_r.a_im) + XW'(s1_r.b_im));
      end
      cau_pkg::OP_SUB: begin
        sat_re = sat_x(XW'(s1_r.a_re) - XW'(s1_r.b_re));
        sat_im = sat_x(XW'(s1_r.a_im) - XW'(s1_r.b_im));
      end
      cau_pkg::OP_NEG: begin
        sat_re = sat_x(XW'(0) - XW'(s1_r.a_re));
        sat_im = sat_x(XW'(0) - XW'(s1_r.a_im));
      end
      cau_pkg::OP_CMP: begin
        d2_nxt.eq = (s1_r.a_re == s1_r.b_re) && (s1_r.a_im == s1_r.b_im);
      end
      default: begin
        // mul and div are finished later; unknown codes give all zeros
      end
    endcase
    if ((s1_r.req_type == cau_pkg::OP_ADD) || (s1_r.req_type == cau_pkg::OP_SUB) ||
        (s1_r.req_type == cau_pkg::OP_NEG)) begin
      d2_nxt.re  = sat_re[W-1:0];
      d2_nxt.im  = sat_im[W-1:0];
      d2_nxt.ovf = sat_re[W] | sat_im[W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    op2_r <= s1_r.req_type;
    d2_r  <= d2_nxt;
  end

  // six products, all exact
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, p_br2, p_bi2;

  cau_mul u_mul_rr (.clk(clk), .a(s1_r.a_re), .b(s1_r.b_re), .p(p_rr));
  cau_mul u_mul_ii (.clk(clk), .a(s1_r.a_im), .b(s1_r.b_im), .p(p_ii));
  cau_mul u_mul_ri (.clk(clk), .a(s1_r.a_re), .b(s1_r.b_im), .p(p_ri));
  cau_mul u_mul_ir (.clk(clk), .a(s1_r.a_im), .b(s1_r.b_re), .p(p_ir));
  cau_mul u_mul_br (.clk(clk), .a(s1_r.b_re), .b(s1_r.b_re), .p(p_br2));
  cau_mul u_mul_bi (.clk(clk), .a(s1_r.b_im), .b(s1_r.b_im), .p(p_bi2));

  // ---- stage 3: products land -------------------------------------------
  logic                        v3_r;
  logic [cau_pkg::OP_BITS-1:0] op3_r;
  dres_t                       d3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    op3_r <= op2_r;
    d3_r  <= d2_r;
  end

  // ---- stage 4: combine products ------------------------------------------
  logic                        v4_r;
  logic [cau_pkg::OP_BITS-1:0] op4_r;
  dres_t                       d4_r;
  logic signed [SW-1:0]        mre4_r, mim4_r, nre4_r, nim4_r;
  logic [PW-1:0]               den4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    op4_r  <= op3_r;
    d4_r   <= d3_r;
    mre4_r <= SW'(p_rr) - SW'(p_ii);    // mul real
    mim4_r <= SW'(p_ri) + SW'(p_ir);    // mul imag
    nre4_r <= SW'(p_rr) + SW'(p_ii);    // A * conj(B), real
    nim4_r <= SW'(p_ir) - SW'(p_ri);    // A * conj(B), imag
    den4_r <= $unsigned(p_br2) + $unsigned(p_bi2);   // |B|^2, never negative
  end

  // ---- stage 5: finish mul, split numerators into sign and magnitude -----
  logic                        v5_r;
  logic [cau_pkg::OP_BITS-1:0] op5_r;
  dres_t                       d5_r, d5_nxt;
  logic [1:0]                  neg5_r, neg5_nxt;
  logic [1:0][PW-1:0]          mag5_r, mag5_nxt;
  logic [PW-1:0]               den5_r;
  logic                        dz5_r;
  logic [W:0]                  msat_re, msat_im;

  always_comb begin
    msat_re = sat_wide(mre4_r);
    msat_im = sat_wide(mim4_r);
    d5_nxt  = d4_r;
    if (op4_r == cau_pkg::OP_MUL) begin
      d5_nxt.re  = msat_re[W-1:0];
      d5_nxt.im  = msat_im[W-1:0];
      d5_nxt.ovf = msat_re[W] | msat_im[W];
    end
    neg5_nxt[0] = nre4_r[SW-1];
    neg5_nxt[1] = nim4_r[SW-1];
    mag5_nxt[0] = PW'(nre4_r[SW-1] ? -nre4_r : nre4_r);
    mag5_nxt[1] = PW'(nim4_r[SW-1] ? -nim4_r : nim4_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    op5_r  <= op4_r;
    d5_r   <= d5_nxt;
    neg5_r <= neg5_nxt;
    mag5_r <= mag5_nxt;
    den5_r <= den4_r;
    dz5_r  <= (den4_r == '0);
  end

  // ---- divider: WORD_BITS+1 stages ------------------------------------------
  logic [1:0][W-1:0] quo;
  logic [1:0]        q_ovf;

  cau_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .mag  (mag5_r),
    .den  (den5_r),
    .quo  (quo),
    .q_ovf(q_ovf)
  );

  // side data delayed to line up with the quotient
  logic vld_r [0:DL];
  sb_t  sb_r  [0:DL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DL; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      vld_r[0] <= v5_r;
      for (int k = 1; k <= DL; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    sb_r[0].op  <= op5_r;
    sb_r[0].neg <= neg5_r;
    sb_r[0].dz  <= dz5_r;
    sb_r[0].d   <= d5_r;
    for (int k = 1; k <= DL; k++) begin
      sb_r[k] <= sb_r[k-1];
    end
  end

  // ---- output stage --------------------------------------------------------
  cau_pkg::cau_out_t out_item_r, out_item_nxt;
  logic              out_valid_r;
  logic [W:0]        dsat_re, dsat_im;

  always_comb begin
    dsat_re                = div_sat(quo[0], q_ovf[0], sb_r[DL].neg[0]);
    dsat_im                = div_sat(quo[1], q_ovf[1], sb_r[DL].neg[1]);
    out_item_nxt.res_re    = sb_r[DL].d.re;
    out_item_nxt.res_im    = sb_r[DL].d.im;
    out_item_nxt.is_equal  = sb_r[DL].d.eq;
    out_item_nxt.div_zero  = 1'b0;
    out_item_nxt.overflow  = sb_r[DL].d.ovf;
    if (sb_r[DL].op == cau_pkg::OP_DIV) begin
      if (sb_r[DL].dz) begin
        // zero divisor: both parts pinned to the top value, no overflow
        out_item_nxt.res_re   = MAX_POS;
        out_item_nxt.res_im   = MAX_POS;
        out_item_nxt.div_zero = 1'b1;
        out_item_nxt.overflow = 1'b0;
      end else begin
        out_item_nxt.res_re   = dsat_re[W-1:0];
        out_item_nxt.res_im   = dsat_im[W-1:0];
        out_item_nxt.overflow = dsat_re[W] | dsat_im[W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[DL];
    end
  end

  always_ff @(posedge clk) begin
    if (vld_r[DL]) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ----- verif/cau_monitor.sv -----
// Result monitor for the complex arithmetic unit: predicts each beat and checks the results.
`timescale 1ns / 1ps

module cau_monitor #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  cau_pkg::cau_in_t  in_item,
  input  logic              out_valid,
  input  cau_pkg::cau_out_t out_item,
  output int                mismatches,
  output int                outstanding
);
  import cau_pkg::*;

  localparam int W = WORD_BITS;
  localparam logic signed [W-1:0] WORD_MAX = {1'b0, {(W-1){1'b1}}};

  typedef logic signed [127:0] wide_t;

  cau_out_t awaited_results[$];

  function automatic logic signed [W-1:0] clamp_word(input wide_t v);
    wide_t hi_lim, lo_lim;
    hi_lim = wide_t'(WORD_MAX);
    lo_lim = ~hi_lim;
    if (v > hi_lim) return hi_lim[W-1:0];
    if (v < lo_lim) return lo_lim[W-1:0];
    return v[W-1:0];
  endfunction

  // quotient scaled by 2^FRAC_BITS, truncated toward zero
  function automatic wide_t div_fixed(input wide_t num, input wide_t den);
    logic [127:0] mag, q;
    mag = num[127] ? -num : num;
    q = (mag << FRAC_BITS) / den;
    return num[127] ? -$signed(q) : $signed(q);
  endfunction

  function automatic cau_out_t compute_complex_op(input cau_in_t req);
    wide_t ar, ai, br, bi, vr, vi, den;
    cau_out_t r;
    r  = '0;
    vr = '0;
    vi = '0;
    ar = wide_t'(req.a_re);
    ai = wide_t'(req.a_im);
    br = wide_t'(req.b_re);
    bi = wide_t'(req.b_im);
    case (req.req_type)
      OP_ADD: begin
        vr = ar + br;
        vi = ai + bi;
      end
      OP_SUB: begin
        vr = ar - br;
        vi = ai - bi;
      end
      OP_MUL: begin
        // arithmetic shift of the exact product rounds toward minus infinity
        vr = (ar * br - ai * bi) >>> FRAC_BITS;
        vi = (ar * bi + ai * br) >>> FRAC_BITS;
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == '0) begin
          r.div_zero = 1'b1;
          vr = wide_t'(WORD_MAX);
          vi = wide_t'(WORD_MAX);
        end else begin
          vr = div_fixed(ar * br + ai * bi, den);
          vi = div_fixed(ai * br - ar * bi, den);
        end
      end
      OP_NEG: begin
        vr = -ar;
        vi = -ai;
      end
      OP_CMP: begin
        r.is_equal = (req.a_re == req.b_re) && (req.a_im == req.b_im);
      end
      default: ;
    endcase
    r.res_re   = clamp_word(vr);
    r.res_im   = clamp_word(vi);
    r.overflow = (vr != wide_t'(r.res_re)) || (vi != wide_t'(r.res_im));
    return r;
  endfunction

  task automatic flag_bad(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    cau_out_t want;
    if (!rst_n) begin
      awaited_results.delete();
      mismatches = 0;
      outstanding <= 0;
    end else begin
      // a result can never belong to the beat taken at the same edge
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          flag_bad($sformatf("result with none awaited: re=%h im=%h eq=%b dz=%b ovf=%b",
                             out_item.res_re, out_item.res_im, out_item.is_equal,
                             out_item.div_zero, out_item.overflow));
        end else begin
          want = awaited_results.pop_front();
          if (out_item.res_re !== want.res_re || out_item.res_im !== want.res_im ||
              out_item.is_equal !== want.is_equal || out_item.div_zero !== want.div_zero ||
              out_item.overflow !== want.overflow) begin
            flag_bad($sformatf({"result mismatch: exp re=%h im=%h eq=%b dz=%b ovf=%b",
                                " got re=%h im=%h eq=%b dz=%b ovf=%b"},
                               want.res_re, want.res_im, want.is_equal, want.div_zero,
                               want.overflow, out_item.res_re, out_item.res_im,
                               out_item.is_equal, out_item.div_zero, out_item.overflow));
          end
        end
      end
      if (start && !busy) awaited_results.push_back(compute_complex_op(in_item));
      outstanding <= awaited_results.size();
    end
  end

endmodule

// ----- verif/testbench.sv -----
// Top of the complex arithmetic unit testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import cau_pkg::*;

  localparam int W              = WORD_BITS;
  localparam int FRAC           = FRAC_BITS_DEF;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int CALM_ITEMS     = 150;   // closing stretch with no gaps
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no beat on either side
  localparam int TAIL_CYCLES    = W + 6 + 12;
  localparam int SMALL_SPAN     = 1 << 20;

  // reserved operation codes; the unit must answer them with an all-zero result
  localparam logic [OP_BITS-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_BITS-1:0] OP_RSVD7 = 3'd7;

  localparam logic signed [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ONE  = 1 << FRAC;

  logic     clk     = 1'b0;
  logic     rst_n   = 1'b0;
  logic     start   = 1'b0;
  cau_in_t  in_item = '0;
  logic     busy;
  logic     out_valid;
  cau_out_t out_item;
  int       mismatches;
  int       outstanding;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  complex_arith_unit_top #(.FRAC_BITS(FRAC)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Prediction and comparison live in the monitor; this module only drives.
  cau_monitor #(.FRAC_BITS(FRAC)) mon (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Watchdog: a hung input handshake or a lost result shows up as a long
  // stretch with no beat moving on either channel.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) quiet = 0;
      else quiet++;
    end
    $display("** complex_arith_unit_top: FAILED **");
    $finish;
  end

  function automatic cau_in_t make_req(input logic [OP_BITS-1:0] op,
                                       input logic signed [W-1:0] ar,
                                       input logic signed [W-1:0] ai,
                                       input logic signed [W-1:0] br,
                                       input logic signed [W-1:0] bi);
    cau_in_t q;
    q.req_type = op;
    q.a_re     = ar;
    q.a_im     = ai;
    q.b_re     = br;
    q.b_im     = bi;
    return q;
  endfunction

  // modest magnitudes, so products and quotients stay mostly in range
  function automatic logic signed [W-1:0] rand_small();
    return int'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN;
  endfunction

  // mix of corner values, full-range words and small values
  function automatic logic signed [W-1:0] rand_word();
    logic signed [W-1:0] w;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 6))
          0:       w = MAXW;
          1:       w = MINW;
          2:       w = '0;
          3:       w = 1;
          4:       w = -1;
          5:       w = ONE;
          default: w = -ONE;
        endcase
      end
      1, 2, 3, 4: w = $urandom;
      default:    w = rand_small();
    endcase
    return w;
  endfunction

  function automatic cau_in_t rand_req();
    cau_in_t q;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) q.req_type = (pick < 2) ? OP_RSVD6 : OP_RSVD7;
    else q.req_type = op_t'(pick % 6);
    q.a_re = rand_word();
    q.a_im = rand_word();
    q.b_re = rand_word();
    q.b_im = rand_word();
    case (q.req_type)
      OP_DIV: begin
        // zero divisor now and then; otherwise often a small divisor
        if ($urandom_range(0, 9) == 0) begin
          q.b_re = '0;
          q.b_im = '0;
        end else if ($urandom_range(0, 1) == 1) begin
          q.b_re = rand_small();
          q.b_im = rand_small();
        end
      end
      OP_CMP: begin
        // equal, off by one bit in either part, or unrelated
        case ($urandom_range(0, 3))
          0: begin
            q.b_re = q.a_re;
            q.b_im = q.a_im;
          end
          1: begin
            q.b_re = q.a_re;
            q.b_im = q.a_im ^ (1 << $urandom_range(0, W - 1));
          end
          2: begin
            q.b_re = q.a_re ^ (1 << $urandom_range(0, W - 1));
            q.b_im = q.a_im;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    // real operand B, as used by the mixed real/complex forms
    if (q.req_type != OP_CMP && $urandom_range(0, 7) == 0) q.b_im = '0;
    return q;
  endfunction

  // Present one beat and hold it until the unit takes it. start stays high
  // afterwards, so back-to-back beats need no extra assignment.
  task automatic send_beat(input cau_in_t req);
    in_item <= req;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic idle_for(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop sending until every predicted result has come back. The first
  // edge is always waited out, since the monitor's count is registered.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    int gap_pct;
    gap_pct = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats: saturation at both ends, rounding, zero divisor,
    // negate of the most negative word, compare hits and misses, reserved ops.
    send_beat(make_req(OP_ADD, MAXW, MAXW, 1, MINW));
    send_beat(make_req(OP_ADD, MINW, 5, MINW, -7));
    send_beat(make_req(OP_SUB, MINW, 0, 1, MINW));
    send_beat(make_req(OP_SUB, 3 * ONE, -ONE, ONE, ONE));
    send_beat(make_req(OP_MUL, MAXW, MAXW, MAXW, MAXW));
    send_beat(make_req(OP_MUL, MINW, MINW, MINW, MINW));
    send_beat(make_req(OP_MUL, -1, 1, 1, 1));            // tiny negative floors
    send_beat(make_req(OP_MUL, 3 * ONE / 2, 2 * ONE, -ONE / 2, ONE / 4));
    send_beat(make_req(OP_MUL, ONE, 0, 123456, -654321));
    send_beat(make_req(OP_DIV, ONE, ONE, 0, 0));          // zero divisor
    send_beat(make_req(OP_DIV, MINW, MAXW, 0, 0));
    send_beat(make_req(OP_DIV, 3 * ONE, 4 * ONE, ONE, 2 * ONE));
    send_beat(make_req(OP_DIV, MAXW, MINW, 1, 0));        // quotient far too big
    send_beat(make_req(OP_DIV, -5 * ONE, 7, -2 * ONE, 0)); // truncation, real B
    send_beat(make_req(OP_DIV, 1, -1, MAXW, MINW));
    send_beat(make_req(OP_DIV, MINW, MINW, -1, -1));
    send_beat(make_req(OP_DIV, ONE, 0, 1, 1));
    send_beat(make_req(OP_NEG, MINW, MAXW, 0, 0));        // most negative word
    send_beat(make_req(OP_NEG, 0, -1, 5, 5));
    send_beat(make_req(OP_CMP, 1234, -5678, 1234, -5678));
    send_beat(make_req(OP_CMP, MINW, MAXW, MAXW, MAXW));
    send_beat(make_req(OP_CMP, 0, 0, 0, 1));
    send_beat(make_req(OP_RSVD6, MAXW, MINW, 1, 1));
    send_beat(make_req(OP_RSVD7, -1, -1, -1, -1));

    // hold off until the pipe is empty before the random part
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // gap density changes per block of beats; some blocks run solid
      if (n % 100 == 0) gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
      if (n >= RANDOM_ITEMS - CALM_ITEMS) gap_pct = 0;
      if (n == RANDOM_ITEMS / 2) wait_drained();
      if ($urandom_range(0, 99) < gap_pct) idle_for($urandom_range(1, 5));
      send_beat(rand_req());
    end

    wait_drained();
    // stray late results would still be caught here
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("** complex_arith_unit_top: PASSED **");
    end else begin
      $display("** complex_arith_unit_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/cau_pkg.sv
sv/cau_mul.sv
sv/cau_div.sv
sv/complex_arith_unit_top.sv
verif/cau_monitor.sv
verif/testbench.sv
